// ----- design/pes_pkg.sv -----
// Shared types and codes for the sparse-state Pauli expectation block.
// Used by pes_ctrl, pes_datapath and the top level; no dependencies.
package pes_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // y_count mod 4 that negates the sum
    localparam logic [1:0] Y_NEG_CODE = 2'd2;
    // term_phase codes that need more than a sign flip
    localparam logic [1:0] PHASE_ZERO = 2'b00;
    localparam logic [1:0] PHASE_NEG2 = 2'b10;

    // Result width after saturation (Q2.30)
    localparam int RES_W  = 32;
    // Binary point of the result
    localparam int RES_FB = 30;

    typedef struct packed {
        logic clr_start;
        logic clr_step;
        logic load_wr;
        logic query_start;
        logic walk_step;
        logic out_load;
    } ctl_t;

    typedef struct packed {
        logic clr_last;
        logic walk_last;
        logic skip_walk;
        logic pipe_busy;
        logic out_full;
    } stat_t;

endpackage

// ----- design/pes_ctrl.sv -----
// Control state machine: clearing pass, load, and the query walk sequence.
// Depends on pes_pkg; drives commands to pes_datapath and reads its status.
module pes_ctrl
    import pes_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [1:0] s_cmd,
    output logic       s_ready,
    output ctl_t       ctl,
    input  stat_t      st
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                ctl.clr_step = 1'b1;
                if (st.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (cmd_t'(s_cmd))
                        CMD_CLEAR: begin
                            ctl.clr_start = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        CMD_LOAD: begin
                            ctl.load_wr = 1'b1;
                        end
                        CMD_QUERY: begin
                            ctl.query_start = 1'b1;
                            state_next      = ST_SETUP;
                        end
                        default: begin
                            // unused code: drop the beat
                        end
                    endcase
                end
            end
            ST_SETUP: begin
                state_next = st.skip_walk ? ST_FINISH : ST_WALK;
            end
            ST_WALK: begin
                ctl.walk_step = 1'b1;
                if (st.walk_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!st.pipe_busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (!st.out_full) begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ----- design/pes_datapath.sv -----
// Datapath: amplitude and index memories, walk pipeline, accumulator, output.
// Depends on pes_pkg; sequenced by pes_ctrl through ctl_t / stat_t.
module pes_datapath
    import pes_pkg::*;
#(
    parameter int NUM_QUBITS = 10,
    parameter int AMP_WIDTH  = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ctl_t                        ctl,
    output stat_t                       st,
    input  logic [NUM_QUBITS-1:0]       s_amp_index,
    input  logic signed [AMP_WIDTH-1:0] s_amplitude,
    input  logic [NUM_QUBITS-1:0]       s_z_mask,
    input  logic [NUM_QUBITS-1:0]       s_x_mask,
    input  logic [4:0]                  s_y_count,
    input  logic signed [1:0]           s_term_phase,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [RES_W-1:0]     m_expectation
);

    localparam int DEPTH  = 1 << NUM_QUBITS;
    localparam int PROD_W = 2 * AMP_WIDTH;
    // right shift that brings a product to Q2.30; negative means left shift
    localparam int SHR    = 2 * (AMP_WIDTH - 1) - RES_FB;
    // sum of up to DEPTH terms, each within +/-2^30
    localparam int ACC_W  = RES_W + NUM_QUBITS + 1;
    // room for negation and doubling by the phase
    localparam int FIN_W  = ACC_W + 2;
    localparam logic signed [FIN_W-1:0] SAT_HI = FIN_W'(signed'(32'h7FFF_FFFF));
    localparam logic signed [FIN_W-1:0] SAT_LO = FIN_W'(signed'(32'h8000_0000));

    // memories: amplitude word carries its valid flag on top
    logic [AMP_WIDTH:0]  amp_mem  [DEPTH];
    logic [NUM_QUBITS-1:0] list_mem [DEPTH];

    logic [NUM_QUBITS-1:0] ptr_reg;
    logic [NUM_QUBITS:0]   count_reg;
    logic                  list_full;

    logic [NUM_QUBITS-1:0] zm_reg;
    logic [NUM_QUBITS-1:0] xm_reg;
    logic [1:0]            yc_reg;
    logic [1:0]            phase_reg;

    logic                  v1_reg, v2_reg, v3_reg;
    logic [NUM_QUBITS-1:0] idx_reg;
    logic [AMP_WIDTH:0]    a_reg, b_reg;
    logic                  par2_reg, par3_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                  m_valid_reg;
    logic signed [RES_W-1:0] m_expectation_reg;

    logic                  amp_we;
    logic [NUM_QUBITS-1:0] amp_waddr;
    logic [AMP_WIDTH:0]    amp_wdata;
    logic signed [AMP_WIDTH-1:0] a_amp, b_amp;
    logic signed [RES_W-1:0] term_scaled;
    logic signed [RES_W-1:0] term_signed;
    logic signed [FIN_W-1:0] acc_ext, acc_flip, fin_val;
    logic signed [RES_W-1:0] sat_val;
    logic                  flip;

    assign list_full = count_reg[NUM_QUBITS];

    // write port shared by the clearing pass and loads
    assign amp_we    = ctl.clr_step || (ctl.load_wr && !list_full);
    assign amp_waddr = ctl.clr_step ? ptr_reg : s_amp_index;
    assign amp_wdata = ctl.clr_step ? '0 : {1'b1, s_amplitude};

    always_ff @(posedge aclk) begin
        if (amp_we) begin
            amp_mem[amp_waddr] <= amp_wdata;
        end
        a_reg <= amp_mem[idx_reg];
        b_reg <= amp_mem[idx_reg ^ xm_reg];
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_wr && !list_full) begin
            list_mem[count_reg[NUM_QUBITS-1:0]] <= s_amp_index;
        end
        idx_reg <= list_mem[ptr_reg];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= '0;
            count_reg   <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ctl.clr_start || ctl.query_start) begin
                ptr_reg <= '0;
            end else if (ctl.clr_step || ctl.walk_step) begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            if (ctl.clr_start) begin
                count_reg <= '0;
            end else if (ctl.load_wr && !list_full) begin
                count_reg <= count_reg + 1'b1;
            end
            v1_reg <= ctl.walk_step;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (ctl.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // unwritten amplitudes read as zero
    assign a_amp = a_reg[AMP_WIDTH] ? signed'(a_reg[AMP_WIDTH-1:0]) : '0;
    assign b_amp = b_reg[AMP_WIDTH] ? signed'(b_reg[AMP_WIDTH-1:0]) : '0;

    generate
        if (SHR >= 0) begin : g_shr
            assign term_scaled = RES_W'(prod_reg >>> SHR);
        end else begin : g_shl
            assign term_scaled = RES_W'(prod_reg) <<< (-SHR);
        end
    endgenerate

    assign term_signed = par3_reg ? -term_scaled : term_scaled;

    always_ff @(posedge aclk) begin
        if (ctl.query_start) begin
            zm_reg    <= s_z_mask;
            xm_reg    <= s_x_mask;
            yc_reg    <= s_y_count[1:0];
            phase_reg <= s_term_phase;
        end
        par2_reg <= ^(idx_reg & zm_reg);
        par3_reg <= par2_reg;
        prod_reg <= a_amp * b_amp;
        if (ctl.query_start) begin
            acc_reg <= '0;
        end else if (v3_reg) begin
            acc_reg <= acc_reg + ACC_W'(term_signed);
        end
        if (ctl.out_load) begin
            m_expectation_reg <= sat_val;
        end
    end

    // final sign, phase and saturation
    assign flip     = (yc_reg == Y_NEG_CODE) ^ phase_reg[1];
    assign acc_ext  = FIN_W'(acc_reg);
    assign acc_flip = flip ? -acc_ext : acc_ext;

    always_comb begin
        case (phase_reg)
            PHASE_ZERO: fin_val = '0;
            PHASE_NEG2: fin_val = acc_flip <<< 1;
            default:    fin_val = acc_flip;
        endcase
        if (fin_val > SAT_HI) begin
            sat_val = SAT_HI[RES_W-1:0];
        end else if (fin_val < SAT_LO) begin
            sat_val = SAT_LO[RES_W-1:0];
        end else begin
            sat_val = fin_val[RES_W-1:0];
        end
    end

    assign st.clr_last  = (ptr_reg == NUM_QUBITS'(DEPTH - 1));
    assign st.walk_last = (({1'b0, ptr_reg} + 1'b1) == count_reg);
    assign st.skip_walk = yc_reg[0] || (count_reg == '0);
    assign st.pipe_busy = v1_reg || v2_reg || v3_reg;
    assign st.out_full  = m_valid_reg && !m_ready;

    assign m_valid       = m_valid_reg;
    assign m_expectation = m_expectation_reg;

endmodule

// ----- design/pauli_expectation_sparse_state.sv -----
// Sparse real state vector with Pauli-string expectation queries. A clear beat
// sweeps all 2^NUM_QUBITS amplitudes, and after reset the same clearing pass
// runs before the first beat is taken. A query holds its result until the
// previous result has left the output register: the walk reads one list entry per
// cycle through the index memory, then both amplitude read ports, one multiplier
// and the accumulator, and a query with odd y_count or an empty list skips the
// walk. A new beat is taken while a finished result waits in the output
// register.
module pauli_expectation_sparse_state
    import pes_pkg::*;
#(
    parameter int NUM_QUBITS = 10,
    parameter int AMP_WIDTH  = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_cmd,
    input  logic [NUM_QUBITS-1:0]       s_amp_index,
    input  logic signed [AMP_WIDTH-1:0] s_amplitude,
    input  logic [NUM_QUBITS-1:0]       s_z_mask,
    input  logic [NUM_QUBITS-1:0]       s_x_mask,
    input  logic [4:0]                  s_y_count,
    input  logic signed [1:0]           s_term_phase,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [RES_W-1:0]     m_expectation
);

    ctl_t  ctl;
    stat_t st;

    pes_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_cmd),
        .s_ready (s_ready),
        .ctl     (ctl),
        .st      (st)
    );

    pes_datapath #(
        .NUM_QUBITS (NUM_QUBITS),
        .AMP_WIDTH  (AMP_WIDTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl),
        .st            (st),
        .s_amp_index   (s_amp_index),
        .s_amplitude   (s_amplitude),
        .s_z_mask      (s_z_mask),
        .s_x_mask      (s_x_mask),
        .s_y_count     (s_y_count),
        .s_term_phase  (s_term_phase),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_expectation (m_expectation)
    );

    // a result never overwrites one that is still waiting
    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_load |-> !(m_valid && !m_ready))
        else $error("result loaded while output register still full");

    // no beat is taken while the memories are being swept or walked
    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.clr_step || ctl.walk_step) |-> !s_ready)
        else $error("input ready during clear or walk");

    // a load writes only on an accepted beat
    a_load_on_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.load_wr |-> (s_valid && s_ready && s_cmd == CMD_LOAD))
        else $error("load write without an accepted load beat");

    // the walk pipeline is empty whenever a result is loaded
    a_drained_at_out: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_load |-> !st.pipe_busy)
        else $error("result loaded before the walk pipeline drained");

endmodule

// ----- tb/pes_expectation_check.sv -----
// Checker for pauli_expectation_sparse_state: watches both channels, keeps its own
// copy of the sparse state, predicts every query result and compares it beat by beat.
// Depends on pes_pkg for the command and y_count codes.
module pes_expectation_check
    import pes_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic [9:0]         s_amp_index,
    input  logic signed [15:0] s_amplitude,
    input  logic [9:0]         s_z_mask,
    input  logic [9:0]         s_x_mask,
    input  logic [4:0]         s_y_count,
    input  logic signed [1:0]  s_term_phase,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_expectation,
    output int                 mismatches,
    output int                 outstanding
);

    localparam int     DEPTH   = 1024;
    localparam longint RES_MAX = 64'sd2147483647;
    localparam longint RES_MIN = -64'sd2147483648;

    logic signed [15:0] amp_mem [DEPTH];
    bit                 amp_set [DEPTH];
    logic [9:0]         index_list [DEPTH];
    int                 list_len;
    logic signed [31:0] result_q [$];

    function automatic logic signed [31:0] pauli_expect(input logic [9:0] zm,
                                                        input logic [9:0] xm,
                                                        input logic [4:0] yc,
                                                        input logic signed [1:0] ph);
        longint     acc;
        longint     a_i;
        longint     a_j;
        logic [9:0] i;
        logic [9:0] j;
        int         k;
        acc = 0;
        if (yc[0])
            return '0;
        for (k = 0; k < list_len; k++) begin
            i = index_list[k];
            j = i ^ xm;
            // an amplitude never loaded since the last clear reads as zero
            a_i = amp_set[i] ? longint'(amp_mem[i]) : 64'sd0;
            a_j = amp_set[j] ? longint'(amp_mem[j]) : 64'sd0;
            // Q1.15 times Q1.15 lands on Q2.30 directly
            if (^(i & zm))
                acc -= a_i * a_j;
            else
                acc += a_i * a_j;
        end
        if (yc[1:0] == Y_NEG_CODE)
            acc = -acc;
        acc = acc * longint'(ph);
        if (acc > RES_MAX)
            acc = RES_MAX;
        if (acc < RES_MIN)
            acc = RES_MIN;
        return acc[31:0];
    endfunction

    always @(posedge aclk) begin
        logic signed [31:0] want;
        if (!aresetn) begin
            foreach (amp_set[n])
                amp_set[n] = 1'b0;
            list_len = 0;
            result_q.delete();
            mismatches <= 0;
            outstanding <= 0;
        end else begin
            // retire the output beat first: it always belongs to an older query
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    mismatches <= mismatches + 1;
                    $display("%0t: unexpected result: expected none, got %0d",
                             $time, m_expectation);
                end else begin
                    want = result_q.pop_front();
                    if (m_expectation !== want) begin
                        mismatches <= mismatches + 1;
                        $display("%0t: expectation mismatch: expected %0d, got %0d",
                                 $time, want, m_expectation);
                    end
                end
            end
            if (s_valid && s_ready) begin
                case (s_cmd)
                    CMD_CLEAR: begin
                        foreach (amp_set[n])
                            amp_set[n] = 1'b0;
                        list_len = 0;
                    end
                    CMD_LOAD: begin
                        // drop loads once the list is full
                        if (list_len < DEPTH) begin
                            index_list[list_len] = s_amp_index;
                            list_len++;
                            amp_mem[s_amp_index] = s_amplitude;
                            amp_set[s_amp_index] = 1'b1;
                        end
                    end
                    CMD_QUERY: begin
                        result_q.push_back(pauli_expect(s_z_mask, s_x_mask,
                                                        s_y_count, s_term_phase));
                    end
                    default: ;
                endcase
            end
            outstanding <= result_q.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
// Top of the pauli_expectation_sparse_state testbench: clock, reset, stimulus,
// receiver back-pressure, watchdog and verdict.
// Depends on pes_pkg, the block itself and pes_expectation_check.
module tb
    import pes_pkg::*;
();

    localparam logic [1:0]        CMD_UNUSED     = 2'd3;
    localparam logic signed [1:0] PHASE_POS      = 2'sb01;
    localparam logic signed [1:0] PHASE_NEG      = 2'sb11;
    localparam logic signed [15:0] AMP_MIN       = 16'sh8000;
    localparam logic signed [15:0] AMP_MAX       = 16'sh7fff;
    localparam int                RANDOM_ITEMS   = 376;
    localparam int                LONG_HOLD      = 2000;
    localparam int                HOLD_AT_RESULT = 40;
    localparam int                STALL_LIMIT    = 20000;
    localparam int                DRAIN_CYCLES   = 1200;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_cmd;
    logic [9:0]         s_amp_index;
    logic signed [15:0] s_amplitude;
    logic [9:0]         s_z_mask;
    logic [9:0]         s_x_mask;
    logic [4:0]         s_y_count;
    logic signed [1:0]  s_term_phase;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_expectation;

    int         mismatches;
    int         outstanding;
    int         stall_cycles;
    int         items_sent;
    int         beats;
    bit         send_idle_on;
    bit         recv_idle_on;
    logic [9:0] loaded [$];

    pauli_expectation_sparse_state dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_amp_index   (s_amp_index),
        .s_amplitude   (s_amplitude),
        .s_z_mask      (s_z_mask),
        .s_x_mask      (s_x_mask),
        .s_y_count     (s_y_count),
        .s_term_phase  (s_term_phase),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_expectation (m_expectation)
    );

    pes_expectation_check u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_amp_index   (s_amp_index),
        .s_amplitude   (s_amplitude),
        .s_z_mask      (s_z_mask),
        .s_x_mask      (s_x_mask),
        .s_y_count     (s_y_count),
        .s_term_phase  (s_term_phase),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_expectation (m_expectation),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // end the run when neither channel moves a beat for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic signed [15:0] rand_amp();
        case ($urandom_range(0, 7))
            0: return AMP_MIN;
            1: return AMP_MAX;
            2: return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [4:0] rand_y_count();
        if ($urandom_range(0, 3) == 0)
            return 5'($urandom_range(0, 31));
        return 5'(2 * $urandom_range(0, 8));
    endfunction

    // favor x masks that pair two loaded indices so the cross terms are nonzero
    function automatic logic [9:0] pick_x_mask();
        int n;
        n = loaded.size();
        if (n >= 2 && $urandom_range(0, 2) != 0)
            return loaded[$urandom_range(0, n - 1)] ^ loaded[$urandom_range(0, n - 1)];
        return ($urandom_range(0, 1) != 0) ? 10'd0 : 10'($urandom);
    endfunction

    task automatic send_beat(input logic [1:0] cmd, input logic [9:0] idx,
                             input logic signed [15:0] amp, input logic [9:0] zm,
                             input logic [9:0] xm, input logic [4:0] yc,
                             input logic signed [1:0] ph);
        int gap;
        gap = send_idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_cmd        <= cmd;
        s_amp_index  <= idx;
        s_amplitude  <= amp;
        s_z_mask     <= zm;
        s_x_mask     <= xm;
        s_y_count    <= yc;
        s_term_phase <= ph;
        s_valid      <= 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (cmd == CMD_CLEAR)
            loaded.delete();
        if (cmd == CMD_LOAD)
            loaded.push_back(idx);
        if (cmd != CMD_UNUSED)
            items_sent++;
        beats++;
        if (beats % 32 == 0)
            send_idle_on = ($urandom_range(0, 3) != 0);
    endtask

    task automatic do_clear();
        send_beat(CMD_CLEAR, 10'($urandom), 16'($urandom), 10'($urandom),
                  10'($urandom), 5'($urandom), 2'($urandom));
    endtask

    task automatic do_load(input logic [9:0] idx, input logic signed [15:0] amp);
        send_beat(CMD_LOAD, idx, amp, 10'($urandom), 10'($urandom), 5'($urandom),
                  2'($urandom));
    endtask

    task automatic do_query(input logic [9:0] zm, input logic [9:0] xm,
                            input logic [4:0] yc, input logic signed [1:0] ph);
        send_beat(CMD_QUERY, 10'($urandom), 16'($urandom), zm, xm, yc, ph);
    endtask

    // result side: random ready gaps, with one long hold to back the block up
    initial begin
        int gap;
        int results;
        m_ready <= 1'b0;
        results = 0;
        recv_idle_on = 1'b1;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (results == HOLD_AT_RESULT)
                gap = LONG_HOLD;
            else
                gap = recv_idle_on ? $urandom_range(0, 19) : 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid)
                @(posedge aclk);
            results++;
            if (results % 24 == 0)
                recv_idle_on = ($urandom_range(0, 3) != 0);
        end
    end

    initial begin
        int start;
        int n;
        logic [9:0] base;
        s_valid      <= 1'b0;
        s_cmd        <= CMD_CLEAR;
        s_amp_index  <= '0;
        s_amplitude  <= '0;
        s_z_mask     <= '0;
        s_x_mask     <= '0;
        s_y_count    <= '0;
        s_term_phase <= '0;
        aresetn      <= 1'b0;
        items_sent   = 0;
        beats        = 0;
        send_idle_on = 1'b1;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty list, extremes, duplicate index, odd Y, phases, unused command
        do_query(10'd0, 10'd0, 5'd0, PHASE_POS);
        do_load(10'd0, AMP_MIN);
        do_load(10'h3ff, AMP_MAX);
        do_load(10'd5, 16'sd1234);
        do_load(10'd5, -16'sd7);
        do_load(10'd10, 16'sd100);
        do_query(10'd0, 10'd0, 5'd0, PHASE_POS);
        do_query(10'h3ff, 10'h3ff, 5'd2, PHASE_NEG);
        do_query(10'd5, 10'd15, 5'd4, PHASE_NEG2);
        do_query(10'h3ff, 10'd0, 5'd1, PHASE_POS);
        do_query(10'h3ff, 10'd0, 5'd31, PHASE_POS);
        do_query(10'd0, 10'd0, 5'd0, PHASE_ZERO);
        // every partner index here was never loaded
        do_query(10'h2aa, 10'd3, 5'd16, PHASE_POS);
        send_beat(CMD_UNUSED, 10'h3ff, AMP_MIN, 10'h3ff, 10'h3ff, 5'd31, PHASE_NEG);
        do_clear();
        do_query(10'd0, 10'd0, 5'd0, PHASE_POS);
        do_load(10'd1, AMP_MIN);
        do_load(10'd2, AMP_MIN);
        do_load(10'd3, AMP_MIN);
        // drive the sum past both saturation limits and onto the exact minimum
        do_query(10'd0, 10'd0, 5'd0, PHASE_POS);
        do_query(10'd0, 10'd0, 5'd0, PHASE_NEG);
        do_query(10'd1, 10'd0, 5'd2, PHASE_NEG2);
        do_query(10'd0, 10'd0, 5'd2, PHASE_NEG2);
        do_clear();

        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                7, 8: begin
                    // noise: any command with any content
                    repeat ($urandom_range(1, 6))
                        send_beat(2'($urandom), 10'($urandom), rand_amp(),
                                  10'($urandom), 10'($urandom), 5'($urandom),
                                  2'($urandom));
                end
                9: begin
                    // broken sequence: query before any load, loads left unqueried
                    do_clear();
                    do_query(10'($urandom), 10'($urandom), rand_y_count(), 2'($urandom));
                    repeat ($urandom_range(1, 8)) do_load(10'($urandom), rand_amp());
                end
                default: begin
                    if ($urandom_range(0, 3) != 0 || loaded.size() > 48)
                        do_clear();
                    n = $urandom_range(1, 16);
                    base = 10'($urandom);
                    // cluster indices so x masks land on loaded partners
                    repeat (n) do_load(base ^ 10'($urandom_range(0, 31)), rand_amp());
                    repeat ($urandom_range(1, 4))
                        do_query(10'($urandom), pick_x_mask(), rand_y_count(),
                                 2'($urandom));
                end
            endcase
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/pes_pkg.sv
design/pes_ctrl.sv
design/pes_datapath.sv
design/pauli_expectation_sparse_state.sv
tb/pes_expectation_check.sv
tb/tb.sv
